[src/assert_macros.svh]
// Assertion helpers shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define BSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define BSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[src/bsa_pkg.sv]
// ----------------------------------------------------------------------------
// bsa_pkg
// Types, widths and codes shared by the budgeted slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam int OP_W        = 2;
  localparam int HANDLE_W    = 16;
  localparam int WEIGHT_W    = 10;
  localparam int IDX_W       = 6;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 7;
  localparam int TOTAL_W     = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int ENTRY_W     = HANDLE_W + WEIGHT_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_OVER_BUDGET = 2'd1,
    ST_FULL        = 2'd2,
    ST_EMPTY       = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT_BUDGET    = 1'b0,
    CFG_BUDGET_UNLIMITED = 1'b1
  } cfg_reg_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch request fields, launch slot read
    logic commit;   // update table state, load result register
  } cmd_t;

endpackage

[src/bsa_ram.sv]
// ----------------------------------------------------------------------------
// bsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/bsa_ctrl.sv]
// ----------------------------------------------------------------------------
// bsa_ctrl
// Request sequencer: capture, execute, result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bsa_pkg::cmd_t cmd_o
);
  import bsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Result register can take a new result this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `BSA_ASSERT(a_result_from_exec, $rose(out_valid_q) |-> $past(state_q == S_EXEC), "result without execute")

endmodule

[src/bsa_dp.sv]
// ----------------------------------------------------------------------------
// bsa_dp
// Slot table, budget check, free-slot search and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsa_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bsa_pkg::cmd_t                  cmd_i,
  input  logic                           cfg_we_i,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [bsa_pkg::OP_W-1:0]       operation_i,
  input  logic [bsa_pkg::HANDLE_W-1:0]   item_handle_i,
  input  logic [bsa_pkg::WEIGHT_W-1:0]   item_weight_i,
  input  logic [bsa_pkg::IDX_W-1:0]      slot_index_i,
  output logic [bsa_pkg::STATUS_W-1:0]   status_o,
  output logic [bsa_pkg::IDX_W-1:0]      placed_slot_o,
  output logic [bsa_pkg::HANDLE_W-1:0]   freed_handle_o,
  output logic [bsa_pkg::WEIGHT_W-1:0]   freed_weight_o,
  output logic [bsa_pkg::OCC_W-1:0]      occupied_count_o,
  output logic [bsa_pkg::TOTAL_W-1:0]    weight_total_o
);
  import bsa_pkg::*;

  // Captured request
  op_e                 req_op_q;
  logic [HANDLE_W-1:0] req_handle_q;
  logic [WEIGHT_W-1:0] req_weight_q;
  logic [IDX_W-1:0]    req_idx_q;

  // Table control state
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [TOTAL_W-1:0]    used_q, used_d;
  logic [CNT_W-1:0]      count_q, count_d;

  // Configuration
  logic [TOTAL_W-1:0] budget_q;
  logic               unlimited_q;

  // Result register
  status_e             res_status_q, res_status_d;
  logic [IDX_W-1:0]    res_placed_q, res_placed_d;
  logic [HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic [WEIGHT_W-1:0] res_weight_q, res_weight_d;
  logic [OCC_W-1:0]    res_occ_q;
  logic [TOTAL_W-1:0]  res_total_q;

  // Search and checks
  logic                 free_found;
  logic [SLOT_AW-1:0]   free_slot;
  logic [TOTAL_W:0]     sum;
  logic                 over;
  logic [SLOT_AW-1:0]   req_addr;
  logic                 idx_ok;
  logic                 hit;
  logic [ENTRY_W-1:0]   rd_entry;
  logic [HANDLE_W-1:0]  rd_handle;
  logic [WEIGHT_W-1:0]  rd_weight;
  logic                 ram_we;

  bsa_ram #(
    .Width (ENTRY_W),
    .Depth (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_slot),
    .wdata_i ({req_handle_q, req_weight_q}),
    .re_i    (cmd_i.capture),
    .raddr_i (SLOT_AW'(slot_index_i)),
    .rdata_o (rd_entry)
  );

  assign rd_handle = rd_entry[ENTRY_W-1:WEIGHT_W];
  assign rd_weight = rd_entry[WEIGHT_W-1:0];

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_AW'(i);
      end
    end
  end

  assign sum      = {1'b0, used_q} + (TOTAL_W + 1)'(req_weight_q);
  assign over     = sum[TOTAL_W] || (!unlimited_q && (sum[TOTAL_W-1:0] > budget_q));
  assign req_addr = SLOT_AW'(req_idx_q);
  assign idx_ok   = (32'(req_idx_q) < 32'(SLOT_COUNT));
  assign hit      = idx_ok && valid_q[req_addr];

  always_comb begin
    valid_d      = valid_q;
    used_d       = used_q;
    count_d      = count_q;
    res_status_d = ST_OK;
    res_placed_d = '0;
    res_handle_d = '0;
    res_weight_d = '0;
    ram_we       = 1'b0;
    case (req_op_q)
      OP_ADD: begin
        if (over) begin
          res_status_d = ST_OVER_BUDGET;
        end else if (!free_found) begin
          res_status_d = ST_FULL;
        end else begin
          ram_we             = cmd_i.commit;
          valid_d[free_slot] = 1'b1;
          used_d             = sum[TOTAL_W-1:0];
          count_d            = count_q + CNT_W'(1);
          res_placed_d       = IDX_W'(free_slot);
        end
      end
      OP_REMOVE: begin
        if (!hit) begin
          res_status_d = ST_EMPTY;
        end else begin
          valid_d[req_addr] = 1'b0;
          used_d            = used_q - TOTAL_W'(rd_weight);
          count_d           = count_q - CNT_W'(1);
          res_handle_d      = rd_handle;
          res_weight_d      = rd_weight;
        end
      end
      OP_CLEAR: begin
        valid_d = '0;
        used_d  = '0;
        count_d = '0;
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Request capture and result register: payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_op_q     <= op_e'(operation_i);
      req_handle_q <= item_handle_i;
      req_weight_q <= item_weight_i;
      req_idx_q    <= slot_index_i;
    end
    if (cmd_i.commit) begin
      res_status_q <= res_status_d;
      res_placed_q <= res_placed_d;
      res_handle_q <= res_handle_d;
      res_weight_q <= res_weight_d;
      res_occ_q    <= OCC_W'(count_d);
      res_total_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.commit) begin
      valid_q <= valid_d;
      used_q  <= used_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q    <= '0;
      unlimited_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_WEIGHT_BUDGET: begin
          budget_q <= cfg_data_i;
        end
        CFG_BUDGET_UNLIMITED: begin
          unlimited_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign status_o         = res_status_q;
  assign placed_slot_o    = res_placed_q;
  assign freed_handle_o   = res_handle_q;
  assign freed_weight_o   = res_weight_q;
  assign occupied_count_o = res_occ_q;
  assign weight_total_o   = res_total_q;

  `BSA_ASSERT(a_count_matches, count_q == CNT_W'($countones(valid_q)), "count mismatch")
  `BSA_ASSERT(a_empty_zero_total, (count_q == '0) |-> (used_q == '0), "total without items")
  `BSA_ASSERT(a_write_free_slot, ram_we |-> !valid_q[free_slot], "write to occupied slot")

endmodule

[src/budgeted_slot_allocator_core.sv]
// Flow: IDLE captures a request; EXEC then commits it and registers the result
// once the result register is free. No new request is taken before the last one
//   commits; EXEC covers the registered read of the slot RAM that a remove needs.
// A stalled result holds; one further request is captured behind it meanwhile.
// Reset (async, active low): all slots empty, count and total zero, budget 0,
//   budget unlimited set. No clearing pass; slot contents stay as they were.
// ----------------------------------------------------------------------------
// budgeted_slot_allocator_core
// Fixed table of slots (handle, weight) with a running weight total and an
// optional weight budget. Add places into the lowest free slot, remove frees
// by index, clear empties the table.
// ----------------------------------------------------------------------------
module budgeted_slot_allocator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bsa_pkg::OP_W-1:0]       operation_i,
  input  logic [bsa_pkg::HANDLE_W-1:0]   item_handle_i,
  input  logic [bsa_pkg::WEIGHT_W-1:0]   item_weight_i,
  input  logic [bsa_pkg::IDX_W-1:0]      slot_index_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bsa_pkg::STATUS_W-1:0]   status_o,
  output logic [bsa_pkg::IDX_W-1:0]      placed_slot_o,
  output logic [bsa_pkg::HANDLE_W-1:0]   freed_handle_o,
  output logic [bsa_pkg::WEIGHT_W-1:0]   freed_weight_o,
  output logic [bsa_pkg::OCC_W-1:0]      occupied_count_o,
  output logic [bsa_pkg::TOTAL_W-1:0]    weight_total_o
);
  import bsa_pkg::*;

  cmd_t cmd;
  logic cfg_we;

  // Config registers are always writable; writes must arrive only while idle, and the block leaves that to the user.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Sequencer: IDLE takes a request (and launches the slot read),
  // EXEC commits the table update once the result register is free.
  bsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Table, budget check, priority encoder over the valid bits, results.
  bsa_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .operation_i      (operation_i),
    .item_handle_i    (item_handle_i),
    .item_weight_i    (item_weight_i),
    .slot_index_i     (slot_index_i),
    .status_o         (status_o),
    .placed_slot_o    (placed_slot_o),
    .freed_handle_o   (freed_handle_o),
    .freed_weight_o   (freed_weight_o),
    .occupied_count_o (occupied_count_o),
    .weight_total_o   (weight_total_o)
  );

endmodule

[tb/budgeted_slot_allocator_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// budgeted_slot_allocator_checker
// Watches the config, request and result channels of the allocator, keeps a
// shadow slot table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module budgeted_slot_allocator_checker
  import bsa_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [OP_W-1:0]         operation_i,
  input  logic [HANDLE_W-1:0]     item_handle_i,
  input  logic [WEIGHT_W-1:0]     item_weight_i,
  input  logic [IDX_W-1:0]        slot_index_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [STATUS_W-1:0]     status_i,
  input  logic [IDX_W-1:0]        placed_slot_i,
  input  logic [HANDLE_W-1:0]     freed_handle_i,
  input  logic [WEIGHT_W-1:0]     freed_weight_i,
  input  logic [OCC_W-1:0]        occupied_count_i,
  input  logic [TOTAL_W-1:0]      weight_total_i,
  output int unsigned             pending_o,
  output int unsigned             mismatch_count_o,
  output logic [SLOT_COUNT-1:0]   occupied_o
);

  typedef struct packed {
    status_e               status;
    logic [IDX_W-1:0]      placed;
    logic [HANDLE_W-1:0]   handle;
    logic [WEIGHT_W-1:0]   weight;
    logic [OCC_W-1:0]      occupied;
    logic [TOTAL_W-1:0]    total;
  } slot_outcome_t;

  // Shadow table and registers
  logic [SLOT_COUNT-1:0] occupied;
  logic [HANDLE_W-1:0]   slot_handle_q [SLOT_COUNT];
  logic [WEIGHT_W-1:0]   slot_weight_q [SLOT_COUNT];
  int unsigned           total;
  int unsigned           filled;
  logic [CFG_DATA_W-1:0] budget;
  logic                  unlimited;

  slot_outcome_t expected_outcomes [$];

  assign occupied_o = occupied;

  function automatic slot_outcome_t predict_outcome(op_e op, logic [HANDLE_W-1:0] handle,
                                                    logic [WEIGHT_W-1:0] weight,
                                                    logic [IDX_W-1:0] idx);
    slot_outcome_t res;
    int unsigned   sum;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_ADD: begin
        sum = total + weight;
        // budget is checked before looking for a free slot
        if (sum > 32'hFFFF || (!unlimited && sum > budget)) begin
          res.status = ST_OVER_BUDGET;
        end else begin
          res.status = ST_FULL;
          for (int i = 0; i < SLOT_COUNT && res.status == ST_FULL; i++) begin
            if (!occupied[i]) begin
              occupied[i]      = 1'b1;
              slot_handle_q[i] = handle;
              slot_weight_q[i] = weight;
              total            = sum;
              filled++;
              res.placed = IDX_W'(i);
              res.status = ST_OK;
            end
          end
        end
      end
      OP_REMOVE: begin
        if (idx >= SLOT_COUNT || !occupied[idx]) begin
          res.status = ST_EMPTY;
        end else begin
          res.handle    = slot_handle_q[idx];
          res.weight    = slot_weight_q[idx];
          occupied[idx] = 1'b0;
          total        -= slot_weight_q[idx];
          filled--;
        end
      end
      OP_CLEAR: begin
        occupied = '0;
        total    = 0;
        filled   = 0;
      end
      default: ;
    endcase
    res.occupied = OCC_W'(filled);
    res.total    = TOTAL_W'(total);
    return res;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      mismatch_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : observe
    slot_outcome_t want;
    if (!rst_ni) begin
      occupied         = '0;
      total            = 0;
      filled           = 0;
      budget           = '0;
      unlimited        = 1'b1;
      mismatch_count_o = 0;
      expected_outcomes.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t ns: result with none expected, expected nothing, got status %0d",
                   $time, status_i);
          mismatch_count_o++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("status", want.status, status_i);
          check_field("placed_slot", want.placed, placed_slot_i);
          check_field("freed_handle", want.handle, freed_handle_i);
          check_field("freed_weight", want.weight, freed_weight_i);
          check_field("occupied_count", want.occupied, occupied_count_i);
          check_field("weight_total", want.total, weight_total_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_outcomes.push_back(predict_outcome(op_e'(operation_i), item_handle_i,
                                                    item_weight_i, slot_index_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_WEIGHT_BUDGET:    budget    = cfg_data_i;
          CFG_BUDGET_UNLIMITED: unlimited = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    pending_o = expected_outcomes.size();
  end

endmodule

[tb/budgeted_slot_allocator_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// budgeted_slot_allocator_core_test
// Drives requests and register writes into the allocator with random gaps
// and result back-pressure; the checker beside the block predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module budgeted_slot_allocator_core_test;
  import bsa_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 3000;  // longest stall burst plus sender gap, many times over
  localparam int PHASE_COUNT    = 7;
  localparam int PHASE_REQUESTS = 190;
  localparam int FLOOD_LENGTH   = 72;    // long enough, at mostly adds, to fill the table from empty

  // Traffic shape of one chunk of random requests
  typedef enum int unsigned {
    MIX_FLOOD,
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } traffic_mix_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic [OP_W-1:0]       operation_i   = '0;
  logic [HANDLE_W-1:0]   item_handle_i = '0;
  logic [WEIGHT_W-1:0]   item_weight_i = '0;
  logic [IDX_W-1:0]      slot_index_i  = '0;
  logic                  out_stall_i   = 1'b0;

  logic                  cfg_ready_o;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [STATUS_W-1:0]   status_o;
  logic [IDX_W-1:0]      placed_slot_o;
  logic [HANDLE_W-1:0]   freed_handle_o;
  logic [WEIGHT_W-1:0]   freed_weight_o;
  logic [OCC_W-1:0]      occupied_count_o;
  logic [TOTAL_W-1:0]    weight_total_o;

  int unsigned           results_owed;
  int unsigned           mismatches;
  logic [SLOT_COUNT-1:0] slot_map;

  logic                  transfer_seen;
  int unsigned           quiet_cycles;
  int unsigned           stall_hold = 0;
  int unsigned           stall_pick;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  budgeted_slot_allocator_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .item_handle_i    (item_handle_i),
    .item_weight_i    (item_weight_i),
    .slot_index_i     (slot_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .placed_slot_o    (placed_slot_o),
    .freed_handle_o   (freed_handle_o),
    .freed_weight_o   (freed_weight_o),
    .occupied_count_o (occupied_count_o),
    .weight_total_o   (weight_total_o)
  );

  budgeted_slot_allocator_checker allocator_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .operation_i      (operation_i),
    .item_handle_i    (item_handle_i),
    .item_weight_i    (item_weight_i),
    .slot_index_i     (slot_index_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_i         (status_o),
    .placed_slot_i    (placed_slot_o),
    .freed_handle_i   (freed_handle_o),
    .freed_weight_i   (freed_weight_o),
    .occupied_count_i (occupied_count_o),
    .weight_total_i   (weight_total_o),
    .pending_o        (results_owed),
    .mismatch_count_o (mismatches),
    .occupied_o       (slot_map)
  );

  // --------------------------------------------------------------------------
  // Request channel helpers. push_request is entered just after a falling
  // edge and returns at the rising edge where the request was taken.
  // --------------------------------------------------------------------------
  task automatic push_request(op_e op, logic [HANDLE_W-1:0] handle,
                              logic [WEIGHT_W-1:0] weight, logic [IDX_W-1:0] idx);
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    item_handle_i <= handle;
    item_weight_i <= weight;
    slot_index_i  <= idx;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send(op_e op, logic [HANDLE_W-1:0] handle,
                      logic [WEIGHT_W-1:0] weight, logic [IDX_W-1:0] idx);
    @(negedge clk_i);
    push_request(op, handle, weight, idx);
  endtask

  // Drop valid for the given number of cycles; zero keeps requests back to back.
  task automatic hold_off(int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register write; only called once the block is idle.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Light phases use mostly zero weights so a tight budget still lets the
  // table fill up.
  function automatic logic [WEIGHT_W-1:0] random_weight(bit light);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (light) begin
      if (r < 90) return '0;
      return WEIGHT_W'($urandom);
    end
    if (r < 15) return '0;
    if (r < 25) return '1;
    if (r < 35) return WEIGHT_W'($urandom_range(1, 15));
    return WEIGHT_W'($urandom);
  endfunction

  // Sender gaps: mostly none or short, now and then a long one.
  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // --------------------------------------------------------------------------
  // Result back-pressure: segments of stall or no stall of random length,
  // including quiet stretches with no stall at all and a few long bursts.
  // --------------------------------------------------------------------------
  initial begin : result_backpressure
    forever begin
      @(negedge clk_i);
      if (stall_hold != 0) begin
        stall_hold--;
      end else begin
        stall_pick = $urandom_range(0, 99);
        if (stall_pick < 10) begin
          out_stall_i <= 1'b0;
          stall_hold = $urandom_range(30, 150);
        end else if (stall_pick < 14) begin
          out_stall_i <= 1'b1;
          stall_hold = $urandom_range(20, 120);
        end else if (stall_pick < 50) begin
          out_stall_i <= 1'b1;
          stall_hold = $urandom_range(0, 3);
        end else begin
          out_stall_i <= 1'b0;
          stall_hold = $urandom_range(0, 4);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too many cycles in a row with no transfer on any channel.
  // --------------------------------------------------------------------------
  assign transfer_seen = (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                         (cfg_valid_i && cfg_ready_o);

  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (transfer_seen) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned           phase;
    int unsigned           n;
    int unsigned           chunk_left;
    int unsigned           add_pct;
    int unsigned           r;
    int unsigned           start;
    bit                    unlimited;
    bit                    light;
    bit                    steady;
    logic [CFG_DATA_W-1:0] budget;
    logic [CFG_DATA_W-1:0] cfg_word;
    logic [IDX_W-1:0]      idx;
    traffic_mix_e          mix;
    op_e                   op;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset settings: no budget check.
    send(OP_REMOVE, 16'h0000, 10'h000, 6'd0);    // remove from an empty table
    send(OP_ADD,    16'h0000, 10'h000, 6'd0);    // lowest slot, zero weight
    send(OP_ADD,    16'hFFFF, 10'h3FF, 6'h3F);   // heaviest item into slot 1
    send(OP_ADD,    16'hA5A5, 10'h200, 6'h2A);
    send(OP_REMOVE, 16'h5A5A, 10'h155, 6'd1);    // frees the heavy item
    send(OP_ADD,    16'h1234, 10'h0F0, 6'h15);   // reuses the hole at slot 1
    send(OP_REMOVE, 16'h0000, 10'h000, 6'h3F);   // top slot, never filled
    send(OP_NOP,    16'hFFFF, 10'h3FF, 6'h3F);   // unused code leaves state alone
    send(OP_REMOVE, 16'h0000, 10'h000, 6'd0);    // zero-weight item comes back
    send(OP_CLEAR,  16'hFFFF, 10'h3FF, 6'h3F);
    send(OP_REMOVE, 16'h0000, 10'h000, 6'd2);    // slot emptied by the clear
    settle();

    // Budget enforced with budget zero: only zero weights fit.
    write_reg(CFG_BUDGET_UNLIMITED, 16'hFFFE);
    send(OP_ADD,    16'hBEEF, 10'h000, 6'd0);
    send(OP_ADD,    16'hCAFE, 10'h001, 6'd0);    // over budget by one
    settle();

    write_reg(CFG_WEIGHT_BUDGET, 16'hFFFF);
    send(OP_ADD,    16'h8001, 10'h3FF, 6'd0);
    send(OP_ADD,    16'h7FFE, 10'h3FF, 6'd0);
    send(OP_CLEAR,  16'h0000, 10'h000, 6'd0);

    // Random phases, each under its own register settings. Every phase opens
    // with a flood of adds that fills the table where the budget allows, then mixes chunks.
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          unlimited = 1'b1; budget = 16'h0000; light = 1'b0;
        end
        1: begin
          unlimited = 1'b0; budget = 16'hFFFF; light = 1'b0;
        end
        2: begin
          unlimited = 1'b0; budget = 16'd300; light = 1'b1;
        end
        3: begin
          unlimited = 1'b0; budget = CFG_DATA_W'($urandom_range(1000, 20000)); light = 1'b0;
        end
        4: begin
          unlimited = 1'b1; budget = CFG_DATA_W'($urandom); light = 1'b0;
        end
        5: begin
          unlimited = 1'b0; budget = 16'h0000; light = 1'b1;
        end
        default: begin
          unlimited = 1'b0; budget = CFG_DATA_W'($urandom_range(20000, 65535)); light = 1'b0;
        end
      endcase

      // The sender pauses here until every result is back.
      settle();
      write_reg(CFG_WEIGHT_BUDGET, budget);
      cfg_word    = CFG_DATA_W'($urandom);   // upper bits are don't care
      cfg_word[0] = unlimited;
      write_reg(CFG_BUDGET_UNLIMITED, cfg_word);

      chunk_left = FLOOD_LENGTH;
      mix        = MIX_FLOOD;
      steady     = 1'b0;
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        if (chunk_left == 0) begin
          chunk_left = $urandom_range(10, 60);
          mix        = traffic_mix_e'($urandom_range(MIX_FILL, MIX_BALANCED));
          steady     = ($urandom_range(0, 3) == 0);
        end
        chunk_left--;

        @(negedge clk_i);
        case (mix)
          MIX_FLOOD: add_pct = 96;
          MIX_FILL:  add_pct = 80;
          MIX_DRAIN: add_pct = 20;
          default:   add_pct = 48;
        endcase
        r = $urandom_range(0, 99);
        if (r < add_pct) op = OP_ADD;
        else if (r < add_pct + 2) op = OP_NOP;
        else if (r < add_pct + 4 && (mix == MIX_DRAIN || mix == MIX_BALANCED)) op = OP_CLEAR;
        else op = OP_REMOVE;

        // Removes mostly target an occupied slot, nearest one at or above a
        // random start; the rest hit any index.
        idx = IDX_W'($urandom);
        if (op == OP_REMOVE && slot_map != '0 && $urandom_range(0, 4) != 0) begin
          start = $urandom_range(0, SLOT_COUNT - 1);
          for (int k = SLOT_COUNT - 1; k >= 0; k--)
            if (slot_map[(start + k) % SLOT_COUNT]) idx = IDX_W'((start + k) % SLOT_COUNT);
        end

        push_request(op, HANDLE_W'($urandom), random_weight(light), idx);

        if ($urandom_range(0, 99) == 0) settle();
        else if (!steady) hold_off(random_gap());
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
